FILE: rtl/core/lcmt_pkg.sv
// Shared types and constants of the Li Chao max line tree.
package lcmt_pkg;

   localparam int CW = 10;
   localparam int SW = 32;
   localparam int IW = 48;
   localparam int LW = 16;
   localparam int VW = 48;

   localparam logic ACT_INSERT = 1'b0;
   localparam logic ACT_QUERY  = 1'b1;

   typedef struct packed {
      logic                 action;
      logic signed [SW-1:0] slope;
      logic signed [IW-1:0] intercept;
      logic [CW-1:0]        range_low;
      logic [CW-1:0]        range_high;
      logic [CW-1:0]        point;
   } req_type;

   typedef struct packed {
      logic [VW-1:0] best_value;
      logic [LW-1:0] best_line;
   } rsp_type;

   typedef struct packed {
      logic                 is_query;
      logic [LW-1:0]        line_id;
      logic signed [SW-1:0] slope;
      logic signed [IW-1:0] intercept;
      logic [CW-1:0]        range_low;
      logic [CW-1:0]        range_high;
      logic [CW-1:0]        point;
   } job_type;

   typedef struct packed {
      logic signed [SW-1:0] slope;
      logic signed [IW-1:0] intercept;
      logic [LW-1:0]        line;
   } node_type;

   typedef struct packed {
      logic ready;
      logic clearing;
   } eng_status_type;

endpackage

FILE: rtl/core/lcmt_front.sv
// Front end: accepts transactions, numbers lines, queues jobs for the engine.
module lcmt_front #(
   parameter int MAX_LINES = 65535
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  lcmt_pkg::req_type          req_data,
   output logic                       job_valid,
   output lcmt_pkg::job_type          job,
   input  lcmt_pkg::eng_status_type   eng_status
);

   lcmt_pkg::job_type q_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic [lcmt_pkg::LW-1:0] line_count_ff, line_count_in;
   logic              accept, push, pop, full;
   lcmt_pkg::job_type new_job;

   assign full      = (count_ff == 2'd2);
   assign busy      = full | eng_status.clearing;
   assign accept    = start & ~busy;
   assign job_valid = (count_ff != 2'd0);
   assign job       = q_ff[rd_ptr_ff];
   assign pop       = job_valid & eng_status.ready;

   always_comb begin
      new_job.is_query   = (req_data.action == lcmt_pkg::ACT_QUERY);
      new_job.line_id    = line_count_ff + 1'b1;
      new_job.slope      = req_data.slope;
      new_job.intercept  = req_data.intercept;
      new_job.range_low  = req_data.range_low;
      new_job.range_high = req_data.range_high;
      new_job.point      = req_data.point;
      push = 1'b0;
      line_count_in = line_count_ff;
      if (accept) begin
         if (new_job.is_query) begin
            push = 1'b1;
         end else if (line_count_ff < lcmt_pkg::LW'(MAX_LINES)) begin
            push = 1'b1;
            line_count_in = line_count_ff + 1'b1;
         end
      end
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff     <= 1'b0;
         rd_ptr_ff     <= 1'b0;
         count_ff      <= 2'd0;
         line_count_ff <= '0;
      end else begin
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         count_ff      <= count_in;
         line_count_ff <= line_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= new_job;
      end
   end

endmodule

FILE: rtl/core/lcmt_engine.sv
// Back end: node store, range walk, per-node line contest and query walk.
module lcmt_engine #(
   parameter int DOMAIN_SIZE = 1024
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [lcmt_pkg::CW-1:0]        domain_high,
   input  logic                           job_valid,
   input  lcmt_pkg::job_type              job,
   output lcmt_pkg::eng_status_type       eng_status,
   output logic                           rsp_strobe,
   output lcmt_pkg::rsp_type              rsp_data
);

   localparam int CW   = lcmt_pkg::CW;
   localparam int LW   = lcmt_pkg::LW;
   localparam int NC   = 2 * DOMAIN_SIZE;
   localparam int PW   = $clog2(NC);
   localparam int PNW  = PW + 1;
   localparam int SD   = PNW;
   localparam int SPW  = $clog2(SD + 1);
   localparam int SIW  = $clog2(SD);
   localparam int DW   = 51;
   localparam int DHM  = (DOMAIN_SIZE - 1 > 1023) ? 1023 : DOMAIN_SIZE - 1;

   typedef enum logic [7:0] {
      E_CLEAR = 8'b00000001,
      E_IDLE  = 8'b00000010,
      E_VISIT = 8'b00000100,
      E_POP   = 8'b00001000,
      E_RD    = 8'b00010000,
      E_LD    = 8'b00100000,
      E_MUL   = 8'b01000000,
      E_DEC   = 8'b10000000
   } eng_state_type;

   lcmt_pkg::node_type mem [NC];
   lcmt_pkg::node_type rdata_ff;

   eng_state_type state_ff, state_in;
   logic [PW-1:0]  clr_ff, clr_in;
   logic [PNW-1:0] p_ff, p_in;
   logic [CW-1:0]  l_ff, l_in, r_ff, r_in;
   logic [CW-1:0]  ql_ff, ql_in, qr_ff, qr_in, x_ff, x_in;
   logic           query_ff, query_in;
   lcmt_pkg::node_type line_ff, line_in, u_ff, u_in;
   logic [SPW-1:0] sp_ff, sp_in;
   logic [PNW-1:0] stk_p_ff [SD];
   logic [CW-1:0]  stk_l_ff [SD];
   logic [CW-1:0]  stk_r_ff [SD];
   logic           push;
   logic signed [32:0] ds_ff, ds_in;
   logic signed [48:0] db_ff, db_in;
   logic signed [43:0] pm_ff, pm_in, pl_ff, pl_in, pr_ff, pr_in;
   logic signed [DW-1:0] best_ff, best_in;
   logic [LW-1:0]  best_id_ff, best_id_in;
   logic           rsp_valid_ff, rsp_valid_in;
   lcmt_pkg::rsp_type rsp_ff, rsp_in;

   logic [CW-1:0]  dh;
   logic [CW:0]    lr_sum;
   logic [CW-1:0]  mid, xm;
   logic           p_out;
   logic [PNW-1:0] p_left, p_right;
   logic [SPW-1:0] spm1;
   logic           covered, go_l, go_r, uwin;
   logic signed [DW-1:0] dm, dl, dr, y;
   logic           we;
   lcmt_pkg::node_type wdata;
   logic [PW-1:0]  waddr;

   function automatic logic gt_d(input logic signed [DW-1:0] d,
                                 input logic [LW-1:0] a, input logic [LW-1:0] b);
      gt_d = (d > 0) || ((d == 0) && (a < b));
   endfunction

   always_comb begin
      if (domain_high == '0) begin
         dh = CW'(1);
      end else if (domain_high > CW'(DHM)) begin
         dh = CW'(DHM);
      end else begin
         dh = domain_high;
      end
   end

   assign lr_sum  = {1'b0, l_ff} + {1'b0, r_ff};
   assign mid     = lr_sum[CW:1];
   assign xm      = query_ff ? x_ff : mid;
   assign p_out   = (p_ff >= PNW'(NC));
   assign p_left  = {p_ff[PNW-2:0], 1'b0};
   assign p_right = {p_ff[PNW-2:0], 1'b1};
   assign spm1    = sp_ff - 1'b1;
   assign covered = (ql_ff <= l_ff) && (r_ff <= qr_ff);
   assign dm      = DW'(pm_ff) + DW'(db_ff);
   assign dl      = DW'(pl_ff) + DW'(db_ff);
   assign dr      = DW'(pr_ff) + DW'(db_ff);
   assign y       = -dm;
   assign uwin    = gt_d(dm, u_ff.line, rdata_ff.line);

   assign eng_status.ready    = (state_ff == E_IDLE);
   assign eng_status.clearing = (state_ff == E_CLEAR);
   assign rsp_strobe          = rsp_valid_ff;
   assign rsp_data            = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      p_in         = p_ff;
      l_in         = l_ff;
      r_in         = r_ff;
      ql_in        = ql_ff;
      qr_in        = qr_ff;
      x_in         = x_ff;
      query_in     = query_ff;
      line_in      = line_ff;
      u_in         = u_ff;
      sp_in        = sp_ff;
      push         = 1'b0;
      ds_in        = ds_ff;
      db_in        = db_ff;
      pm_in        = pm_ff;
      pl_in        = pl_ff;
      pr_in        = pr_ff;
      best_in      = best_ff;
      best_id_in   = best_id_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      we           = 1'b0;
      wdata        = u_ff;
      waddr        = p_ff[PW-1:0];
      go_l         = 1'b0;
      go_r         = 1'b0;
      case (state_ff)
         E_CLEAR: begin
            we    = 1'b1;
            wdata = '0;
            waddr = clr_ff;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == PW'(NC - 1)) begin
               state_in = E_IDLE;
            end
         end
         E_IDLE: begin
            if (job_valid) begin
               p_in       = PNW'(1);
               l_in       = '0;
               r_in       = dh;
               ql_in      = job.range_low;
               qr_in      = job.range_high;
               x_in       = job.point;
               query_in   = job.is_query;
               line_in.slope     = job.slope;
               line_in.intercept = job.intercept;
               line_in.line      = job.line_id;
               sp_in      = '0;
               best_in    = '0;
               best_id_in = '0;
               if (job.is_query) begin
                  u_in = '0;
                  if (job.point > dh) begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = '0;
                  end else begin
                     state_in = E_RD;
                  end
               end else begin
                  state_in = E_VISIT;
               end
            end
         end
         E_VISIT: begin
            if (p_out) begin
               state_in = E_POP;
            end else if (covered) begin
               u_in     = line_ff;
               state_in = E_RD;
            end else if (l_ff == r_ff) begin
               state_in = E_POP;
            end else begin
               go_l = (ql_ff <= mid);
               go_r = (mid < qr_ff);
               if (go_l) begin
                  push = go_r;
                  sp_in = go_r ? sp_ff + 1'b1 : sp_ff;
                  p_in = p_left;
                  r_in = mid;
               end else if (go_r) begin
                  p_in = p_right;
                  l_in = mid + 1'b1;
               end else begin
                  state_in = E_POP;
               end
            end
         end
         E_POP: begin
            if (sp_ff == '0) begin
               state_in = E_IDLE;
            end else begin
               p_in     = stk_p_ff[spm1[SIW-1:0]];
               l_in     = stk_l_ff[spm1[SIW-1:0]];
               r_in     = stk_r_ff[spm1[SIW-1:0]];
               sp_in    = spm1;
               state_in = E_VISIT;
            end
         end
         E_RD: begin
            if (p_out) begin
               if (query_ff) begin
                  rsp_valid_in       = 1'b1;
                  rsp_in.best_value  = best_ff[lcmt_pkg::VW-1:0];
                  rsp_in.best_line   = best_id_ff;
                  state_in           = E_IDLE;
               end else begin
                  state_in = E_POP;
               end
            end else begin
               state_in = E_LD;
            end
         end
         E_LD: begin
            ds_in    = 33'(u_ff.slope) - 33'(rdata_ff.slope);
            db_in    = 49'(u_ff.intercept) - 49'(rdata_ff.intercept);
            state_in = E_MUL;
         end
         E_MUL: begin
            pm_in    = ds_ff * $signed({1'b0, xm});
            pl_in    = ds_ff * $signed({1'b0, l_ff});
            pr_in    = ds_ff * $signed({1'b0, r_ff});
            state_in = E_DEC;
         end
         E_DEC: begin
            if (query_ff) begin
               if ((y > best_ff) || ((y == best_ff) && (rdata_ff.line < best_id_ff))) begin
                  best_in    = y;
                  best_id_in = rdata_ff.line;
               end
               if (l_ff == r_ff) begin
                  rsp_valid_in      = 1'b1;
                  rsp_in.best_value = best_in[lcmt_pkg::VW-1:0];
                  rsp_in.best_line  = best_id_in;
                  state_in          = E_IDLE;
               end else if (x_ff <= mid) begin
                  p_in     = p_left;
                  r_in     = mid;
                  state_in = E_RD;
               end else begin
                  p_in     = p_right;
                  l_in     = mid + 1'b1;
                  state_in = E_RD;
               end
            end else begin
               we    = 1'b1;
               wdata = uwin ? u_ff : rdata_ff;
               u_in  = uwin ? rdata_ff : u_ff;
               go_l  = uwin ? gt_d(-dl, rdata_ff.line, u_ff.line)
                            : gt_d(dl, u_ff.line, rdata_ff.line);
               go_r  = uwin ? gt_d(-dr, rdata_ff.line, u_ff.line)
                            : gt_d(dr, u_ff.line, rdata_ff.line);
               if (go_l) begin
                  p_in     = p_left;
                  r_in     = mid;
                  state_in = E_RD;
               end else if (go_r) begin
                  p_in     = p_right;
                  l_in     = mid + 1'b1;
                  state_in = E_RD;
               end else begin
                  state_in = E_POP;
               end
            end
         end
         default: begin
            state_in = E_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= E_CLEAR;
         clr_ff       <= '0;
         sp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         sp_ff        <= sp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff       <= p_in;
      l_ff       <= l_in;
      r_ff       <= r_in;
      ql_ff      <= ql_in;
      qr_ff      <= qr_in;
      x_ff       <= x_in;
      query_ff   <= query_in;
      line_ff    <= line_in;
      u_ff       <= u_in;
      ds_ff      <= ds_in;
      db_ff      <= db_in;
      pm_ff      <= pm_in;
      pl_ff      <= pl_in;
      pr_ff      <= pr_in;
      best_ff    <= best_in;
      best_id_ff <= best_id_in;
      rsp_ff     <= rsp_in;
      if (push) begin
         stk_p_ff[sp_ff[SIW-1:0]] <= p_right;
         stk_l_ff[sp_ff[SIW-1:0]] <= mid + 1'b1;
         stk_r_ff[sp_ff[SIW-1:0]] <= r_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[p_ff[PW-1:0]];
   end

endmodule

FILE: rtl/core/li_chao_max_line_tree_top.sv
// Top level of the Li Chao max line tree: configuration register and front/engine wiring.
// Keeps the upper envelope of lines over points 0..domain_high (a zero domain_high acts as 1 and
// values above min(DOMAIN_SIZE-1, 1023) are clamped). After reset all 2*DOMAIN_SIZE nodes of
// the store are swept to zero with busy high. A query walks one root-to-leaf path, passing
// through the read, load, multiply and decide states at each level; an insert walks the
// range nodes, returning to stacked branches, and runs the same read, load, multiply and
// decide states for each node visited by the line contest. Up to two transactions queue
// ahead of the engine; the receiver cannot stall, each result shows for one cycle.
module li_chao_max_line_tree_top #(
   parameter int DOMAIN_SIZE = 1024,
   parameter int MAX_LINES   = 65535
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  lcmt_pkg::req_type          req_data,
   output logic                       rsp_strobe,
   output lcmt_pkg::rsp_type          rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [lcmt_pkg::CW-1:0]    csr_data
);

   logic [lcmt_pkg::CW-1:0]  domain_high_ff, domain_high_in;
   logic                     job_valid;
   lcmt_pkg::job_type        job;
   lcmt_pkg::eng_status_type eng_status;

   assign csr_ready      = 1'b1;
   assign domain_high_in = (csr_valid & csr_ready) ? csr_data : domain_high_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         domain_high_ff <= lcmt_pkg::CW'(1023);
      end else begin
         domain_high_ff <= domain_high_in;
      end
   end

   lcmt_front #(
      .MAX_LINES (MAX_LINES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .job_valid  (job_valid),
      .job        (job),
      .eng_status (eng_status)
   );

   lcmt_engine #(
      .DOMAIN_SIZE (DOMAIN_SIZE)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .domain_high (domain_high_ff),
      .job_valid   (job_valid),
      .job         (job),
      .eng_status  (eng_status),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data)
   );

endmodule
